@@ rtl/core/wsrfd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsrfd_pkg
// Types, codes and constants shared by the weather sensor frame decoder.
// ----------------------------------------------------------------------------
package wsrfd_pkg;

    // Frame layout
    localparam logic [7:0] FRAME_PULSES = 8'd74;
    localparam logic [7:0] DATA_FIRST   = 8'd2;
    localparam logic [7:0] DATA_LAST    = 8'd64;
    localparam logic [7:0] CHECK_FIRST  = 8'd66;
    localparam logic [7:0] CHECK_LAST   = 8'd72;
    localparam logic [7:0] COUNT_MAX    = 8'd255;

    // Sensor table
    localparam int TABLE_ENTRIES = 5;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration
    localparam logic [7:0]  CFG_THRESHOLD   = 8'd0;
    localparam logic [7:0]  CFG_SCALE       = 8'd1;
    localparam logic [15:0] THRESHOLD_RESET = 16'hA00;
    localparam logic [7:0]  SCALE_RESET     = 8'd1;

    // Opcodes
    localparam logic OP_PULSE    = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_BAD_COUNT  = 3'd0;
    localparam logic [2:0] ST_BAD_CHECK  = 3'd1;
    localparam logic [2:0] ST_DECODED    = 3'd2;
    localparam logic [2:0] ST_REGISTERED = 3'd3;
    localparam logic [2:0] ST_REFUSED    = 3'd4;

    // Message kinds
    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_TEMP_HUM = 3'd1;
    localparam logic [2:0] KIND_RAIN     = 3'd2;
    localparam logic [2:0] KIND_WIND     = 3'd3;
    localparam logic [2:0] KIND_DIR_GUST = 3'd4;
    localparam logic [2:0] KIND_OTHER    = 3'd5;

    // Nibble checks
    localparam logic [3:0] N2_MASK       = 4'h6;
    localparam logic [3:0] N3_RAIN       = 4'h3;
    localparam logic [3:0] N3_WIND       = 4'h1;
    localparam logic [3:0] N3_DIR_MASK   = 4'h7;
    localparam logic [3:0] CHECK_SEED_RN = 4'h7;
    localparam logic [3:0] CHECK_SEED    = 4'hF;

    // x / 45 for x < 512 as (x * 1457) >> 16
    localparam logic [10:0] DIR_RECIP = 11'd1457;

    typedef struct packed {
        logic        opcode;
        logic [15:0] pulse_length;
        logic        last_pulse;
        logic [7:0]  sensor_id;
        logic [7:0]  target_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [7:0]        rolling_code;
        logic [7:0]        base_slot;
        logic [2:0]        kind;
        logic signed [11:0] temperature;
        logic [7:0]        humidity;
        logic [15:0]       rain_delta;
        logic [7:0]        wind_speed;
        logic [3:0]        wind_direction;
        logic [7:0]        wind_gust;
    } out_item_t;

    typedef struct packed {
        logic        is_reg;
        logic        count_ok;
        logic [31:0] data_bits;
        logic [3:0]  check_bits;
        logic [7:0]  sensor_id;
        logic [7:0]  target_slot;
    } job_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

@@ rtl/core/wsrfd_front.sv @@
// ----------------------------------------------------------------------------
// wsrfd_front
// Accepts pulses and register requests, assembles frame bits, emits jobs.
// ----------------------------------------------------------------------------
module wsrfd_front
    import wsrfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    input  logic [15:0] threshold,
    input  logic [7:0]  scale,
    input  logic      queue_full,
    output logic      push,
    output job_t      push_job
);

    logic [7:0]  count_reg, count_next;
    logic [31:0] data_reg, data_next;
    logic [3:0]  check_reg, check_next;

    logic        accept;
    logic [23:0] scaled;
    logic        one;
    logic [7:0]  idx;
    logic [31:0] data_upd;
    logic [3:0]  check_upd;

    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;

    always_comb
    begin
        scaled    = 24'(in_item.pulse_length) * 24'(scale);
        one       = scaled > {8'd0, threshold};
        idx       = (count_reg == COUNT_MAX) ? count_reg : count_reg + 8'd1;
        data_upd  = data_reg;
        check_upd = check_reg;
        if (!idx[0] && idx >= DATA_FIRST && idx <= DATA_LAST)
        begin
            data_upd = {one, data_reg[31:1]};
        end
        else if (!idx[0] && idx >= CHECK_FIRST && idx <= CHECK_LAST)
        begin
            check_upd = {one, check_reg[3:1]};
        end

        count_next = count_reg;
        data_next  = data_reg;
        check_next = check_reg;
        push       = 1'b0;

        push_job.is_reg      = (in_item.opcode == OP_REGISTER);
        push_job.count_ok    = (idx == FRAME_PULSES);
        push_job.data_bits   = data_upd;
        push_job.check_bits  = check_upd;
        push_job.sensor_id   = in_item.sensor_id;
        push_job.target_slot = in_item.target_slot;

        if (accept)
        begin
            if (in_item.opcode == OP_REGISTER)
            begin
                push = 1'b1;
            end
            else if (in_item.last_pulse)
            begin
                // Hand the finished frame off and start over
                push       = 1'b1;
                count_next = '0;
                data_next  = '0;
                check_next = '0;
            end
            else
            begin
                count_next = idx;
                data_next  = data_upd;
                check_next = check_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            data_reg  <= '0;
            check_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            data_reg  <= data_next;
            check_reg <= check_next;
        end
    end

endmodule

@@ rtl/core/wsrfd_queue.sv @@
// ----------------------------------------------------------------------------
// wsrfd_queue
// Short job FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module wsrfd_queue
    import wsrfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t status
);

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign head_job     = mem[rd_ptr_reg];
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/wsrfd_back.sv @@
// ----------------------------------------------------------------------------
// wsrfd_back
// Judges frames and register requests against the sensor table, drives results.
// ----------------------------------------------------------------------------
module wsrfd_back
    import wsrfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      job_valid,
    input  job_t      job,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [7:0]  ids_reg   [TABLE_ENTRIES];
    logic [7:0]  slots_reg [TABLE_ENTRIES];
    logic [15:0] rain_base_reg, rain_next;
    logic        out_valid_reg;
    out_item_t   out_reg;

    out_item_t              res;
    logic [TABLE_ENTRIES-1:0] tbl_we;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic                   free_seen;
    logic [7:0]             key;
    logic [7:0]             found_slot;
    logic [6:0]             sum;
    logic [3:0]             calc;
    logic [3:0]             n2, n3, n6, n7;
    logic                   n2_special;
    logic [15:0]            rain, base_adj;
    logic [8:0]             dir9;
    logic [19:0]            dir_prod;

    assign pop       = job_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        key = job.is_reg ? job.sensor_id : job.data_bits[7:0];

        // First matching entry wins
        found_slot = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (ids_reg[i] == key)
            begin
                found_slot = slots_reg[i];
            end
        end

        free_oh   = '0;
        free_seen = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (!free_seen && ids_reg[i] == 8'd0)
            begin
                free_oh[i] = 1'b1;
                free_seen  = 1'b1;
            end
        end

        n2 = job.data_bits[11:8];
        n3 = job.data_bits[15:12];
        n6 = job.data_bits[27:24];
        n7 = job.data_bits[31:28];
        n2_special = ((n2 & N2_MASK) == N2_MASK);

        sum = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + 7'(job.data_bits[4*i +: 4]);
        end
        calc = (n2_special && n3 == N3_RAIN) ? (CHECK_SEED_RN + sum[3:0])
                                             : (CHECK_SEED - sum[3:0]);

        rain     = job.data_bits[31:16];
        base_adj = (rain < rain_base_reg) ? rain : rain_base_reg;
        dir9     = job.data_bits[23:15];
        dir_prod = 20'(dir9) * 20'(DIR_RECIP);

        res       = '0;
        tbl_we    = '0;
        rain_next = rain_base_reg;

        if (job.is_reg)
        begin
            res.rolling_code = job.sensor_id;
            res.base_slot    = job.target_slot;
            if (job.target_slot != 8'd0 && found_slot == 8'd0 && free_seen)
            begin
                res.status = ST_REGISTERED;
                tbl_we     = free_oh;
            end
            else
            begin
                res.status = ST_REFUSED;
            end
        end
        else if (!job.count_ok)
        begin
            res.status = ST_BAD_COUNT;
        end
        else if (job.check_bits != calc)
        begin
            res.status = ST_BAD_CHECK;
        end
        else
        begin
            res.status       = ST_DECODED;
            res.rolling_code = key;
            res.base_slot    = found_slot;
            if (found_slot != 8'd0)
            begin
                if (!n2_special)
                begin
                    res.kind        = KIND_TEMP_HUM;
                    res.temperature = job.data_bits[23:12];
                    res.humidity    = 8'(n7) * 8'd10 + 8'(n6);
                end
                else if (n3 == N3_RAIN)
                begin
                    res.kind       = KIND_RAIN;
                    res.rain_delta = (base_adj != 16'd0) ? rain - base_adj : 16'd0;
                    rain_next      = rain;
                end
                else if (n3 == N3_WIND)
                begin
                    res.kind       = KIND_WIND;
                    res.wind_speed = job.data_bits[31:24];
                end
                else if ((n3 & N3_DIR_MASK) == N3_DIR_MASK)
                begin
                    res.kind           = KIND_DIR_GUST;
                    res.wind_direction = dir_prod[19:16];
                    res.wind_gust      = job.data_bits[31:24];
                end
                else
                begin
                    res.kind = KIND_OTHER;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rain_base_reg <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                ids_reg[i]   <= '0;
                slots_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= pop || (out_valid_reg && out_stall);
            if (pop)
            begin
                rain_base_reg <= rain_next;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (tbl_we[i])
                    begin
                        ids_reg[i]   <= job.sensor_id;
                        slots_reg[i] <= job.target_slot;
                    end
                end
            end
        end
    end

endmodule

@@ rtl/core/weather_sensor_rf_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// weather_sensor_rf_frame_decoder
// Radio pulse frame decoder for a weather sensor family with a sensor table.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the queue has room and the output
//   does not stall; the front's 16x8 scale-and-compare path and the judge
//   in the back both take one item each clock. A job is written into the
//   queue, then judged into the result register, held back while stalled.
// Reset: asynchronous; the sensor table, rain base and frame clear at once,
//   configuration returns to threshold 0xA00 and scale 1. No clearing pass.
// ----------------------------------------------------------------------------
module weather_sensor_rf_frame_decoder
    import wsrfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input channel: pulse samples and register requests
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    // Result channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0] threshold_reg;
    logic [7:0]  scale_reg;

    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head_job;
    q_status_t q_status;

    // Configuration: always ready; writes outside the register list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            scale_reg     <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD: threshold_reg <= cfg_data;
                CFG_SCALE:     scale_reg     <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    // Front: count pulses, shift in frame bits, queue a job per frame end or
    // register request. Stalls only when the job queue is full.
    wsrfd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .threshold  (threshold_reg),
        .scale      (scale_reg),
        .queue_full (q_status.full),
        .push       (push),
        .push_job   (push_job)
    );

    // Queue: holds jobs in order so table updates and lookups stay ordered.
    wsrfd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    // Back: checksum, table lookup or registration, message classification,
    // result register. Advance whenever the result register is free or drains.
    wsrfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!q_status.empty),
        .job       (head_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    // Never push into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    // Occupancy stays within depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // A result that transfers while jobs wait is followed by the next result
    a_refill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !q_status.empty) |=> out_valid)
        else $error("back stage failed to refill result");

    // A pop only happens with a job present
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

@@ tb/sv/tb_weather_sensor_rf_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_weather_sensor_rf_frame_decoder
// Self-checking bench for the weather sensor frame decoder. Pulse frames and
// sensor registrations go in over a valid/stall channel. A cycle-free
// predictor tracks the frame, the sensor roster and the rain base, and queues
// the report due for each frame end or registration. Every report that comes
// out is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module tb_weather_sensor_rf_frame_decoder;
    import wsrfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT_NS = 3_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_STEP     = 45;

    // Sensor ids that the roster gets in the directed part
    localparam logic [7:0] ID_A = 8'h2A;
    localparam logic [7:0] ID_B = 8'h51;
    localparam logic [7:0] ID_C = 8'hFF;
    localparam logic [7:0] ID_D = 8'h01;
    localparam logic [7:0] ID_E = 8'h99;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_item;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    // Predictor state: configuration, frame in flight, roster, rain base
    logic [15:0] live_threshold = THRESHOLD_RESET;
    logic [7:0]  live_scale     = SCALE_RESET;
    logic [7:0]  frame_count    = '0;
    logic [31:0] frame_data     = '0;
    logic [3:0]  frame_check    = '0;
    logic [7:0]  roster_id   [TABLE_ENTRIES];
    logic [7:0]  roster_slot [TABLE_ENTRIES];
    logic [15:0] rain_ref       = '0;

    out_item_t   expected_reports[$];
    int          mismatch_count    = 0;
    int          reports_checked   = 0;
    int          reports_predicted = 0;
    int          items_sent        = 0;

    // Traffic shaping
    bit          calm_tail    = 1'b0;
    int          hold_request = 0;
    int          stall_left   = 0;
    logic [15:0] rain_counter = 16'h0100;
    logic [7:0]  known_ids [5] = '{ID_A, ID_B, ID_C, ID_D, ID_E};

    weather_sensor_rf_frame_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Nibble checksum of a data word; rain frames use a different seed and add
    function automatic logic [3:0] nibble_check(logic [31:0] d);
        logic [3:0] sum;
        int         i;
        sum = '0;
        for (i = 0; i < 8; i++)
            sum = sum + d[4*i +: 4];
        if ((d[11:8] & N2_MASK) == N2_MASK && d[15:12] == N3_RAIN)
            return CHECK_SEED_RN + sum;
        return CHECK_SEED - sum;
    endfunction

    // First roster entry holding the code wins; a free entry matches code 0
    function automatic logic [7:0] slot_of(logic [7:0] code);
        int i;
        for (i = 0; i < TABLE_ENTRIES; i++)
            if (roster_id[i] == code)
                return roster_slot[i];
        return 8'd0;
    endfunction

    // Advance the predictor by one accepted input transfer; queue any report
    function automatic void predict_transfer(in_item_t it);
        out_item_t   r;
        logic [23:0] scaled;
        logic        one;
        logic [3:0]  n2;
        logic [3:0]  n3;
        logic [15:0] rain_now;
        int          i;
        r = '0;
        if (it.opcode == OP_REGISTER)
        begin
            r.status       = ST_REFUSED;
            r.rolling_code = it.sensor_id;
            r.base_slot    = it.target_slot;
            if (it.target_slot != 0 && slot_of(it.sensor_id) == 0)
            begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (roster_id[i] == 0)
                    begin
                        roster_id[i]   = it.sensor_id;
                        roster_slot[i] = it.target_slot;
                        r.status       = ST_REGISTERED;
                        break;
                    end
                end
            end
            expected_reports.push_back(r);
            reports_predicted++;
            return;
        end

        // Count the pulse (saturating) and shift in its bit, LSB first
        if (frame_count != COUNT_MAX)
            frame_count = frame_count + 8'd1;
        scaled = 24'(it.pulse_length) * 24'(live_scale);
        one    = scaled > {8'd0, live_threshold};
        if (!frame_count[0] && frame_count >= DATA_FIRST && frame_count <= DATA_LAST)
            frame_data = {one, frame_data[31:1]};
        else if (!frame_count[0] && frame_count >= CHECK_FIRST && frame_count <= CHECK_LAST)
            frame_check = {one, frame_check[3:1]};
        if (!it.last_pulse)
            return;

        // Judge the frame: count, then checksum, then lookup and message type
        if (frame_count != FRAME_PULSES)
            r.status = ST_BAD_COUNT;
        else if (frame_check != nibble_check(frame_data))
            r.status = ST_BAD_CHECK;
        else
        begin
            r.status       = ST_DECODED;
            r.rolling_code = frame_data[7:0];
            r.base_slot    = slot_of(frame_data[7:0]);
            n2 = frame_data[11:8];
            n3 = frame_data[15:12];
            if (r.base_slot != 0)
            begin
                if ((n2 & N2_MASK) != N2_MASK)
                begin
                    r.kind        = KIND_TEMP_HUM;
                    r.temperature = frame_data[23:12];
                    r.humidity    = 8'(frame_data[31:28]) * 8'd10 + 8'(frame_data[27:24]);
                end
                else if (n3 == N3_RAIN)
                begin
                    r.kind   = KIND_RAIN;
                    rain_now = frame_data[31:16];
                    if (rain_now < rain_ref)
                        rain_ref = rain_now;
                    if (rain_ref != 0)
                        r.rain_delta = rain_now - rain_ref;
                    rain_ref = rain_now;
                end
                else if (n3 == N3_WIND)
                begin
                    r.kind       = KIND_WIND;
                    r.wind_speed = frame_data[31:24];
                end
                else if ((n3 & N3_DIR_MASK) == N3_DIR_MASK)
                begin
                    r.kind           = KIND_DIR_GUST;
                    r.wind_direction = 4'(frame_data[23:15] / DIR_STEP);
                    r.wind_gust      = frame_data[31:24];
                end
                else
                    r.kind = KIND_OTHER;
            end
        end
        frame_count = '0;
        frame_data  = '0;
        frame_check = '0;
        expected_reports.push_back(r);
        reports_predicted++;
    endfunction

    // ------------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(string text);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t ns: report %0d mismatch: %s", $time, reports_checked, text);
    endfunction

    function automatic void field_check(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
            note_mismatch($sformatf("%s expected %0h got %0h", field, want, got));
    endfunction

    function automatic void check_report(out_item_t got);
        out_item_t want;
        reports_checked++;
        if (expected_reports.size() == 0)
        begin
            note_mismatch($sformatf("report %h with nothing pending", got));
            return;
        end
        want = expected_reports.pop_front();
        field_check("status",         want.status,         got.status);
        field_check("rolling_code",   want.rolling_code,   got.rolling_code);
        field_check("base_slot",      want.base_slot,      got.base_slot);
        field_check("kind",           want.kind,           got.kind);
        field_check("temperature",    want.temperature,    got.temperature);
        field_check("humidity",       want.humidity,       got.humidity);
        field_check("rain_delta",     want.rain_delta,     got.rain_delta);
        field_check("wind_speed",     want.wind_speed,     got.wind_speed);
        field_check("wind_direction", want.wind_direction, got.wind_direction);
        field_check("wind_gust",      want.wind_gust,      got.wind_gust);
    endfunction

    // Sample every channel at the edge: check results first, since a result
    // never belongs to the input transfer of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_report(out_item);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_THRESHOLD)
                    live_threshold = cfg_data;
                else if (cfg_index == CFG_SCALE)
                    live_scale = cfg_data[7:0];
            end
            if (in_valid && !in_stall)
                predict_transfer(in_item);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request; drop
    // all stalling in the calm tail of the run
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_request != 0)
        begin
            stall_left   = hold_request - 1;
            hold_request = 0;
            out_stall <= 1'b1;
        end
        else if (!calm_tail && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one item and hold it until the transfer happens. Valid stays high
    // afterwards so the next item can follow without a bubble; drop it with
    // input_idle before any wait.
    task automatic offer_item(input in_item_t item);
        int gap;
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic input_idle();
        in_valid <= 1'b0;
    endtask

    task automatic offer_register(input logic [7:0] id, input logic [7:0] slot);
        in_item_t item;
        item.opcode       = OP_REGISTER;
        item.pulse_length = 16'($urandom_range(0, 65535));
        item.last_pulse   = 1'($urandom_range(0, 1));
        item.sensor_id    = id;
        item.target_slot  = slot;
        offer_item(item);
    endtask

    // Pick a pulse length that lands on the wanted side of the threshold
    function automatic logic [15:0] pulse_for(logic one);
        int unsigned knee;
        int unsigned lo;
        int unsigned hi;
        knee = (live_scale == 0) ? 65535 : live_threshold / live_scale;
        if (one && knee < 65535)
        begin
            hi = knee + 1 + $urandom_range(0, 3000);
            if (hi > 65535)
                hi = 65535;
            return 16'($urandom_range(knee + 1, hi));
        end
        lo = (knee > 3000) ? knee - $urandom_range(0, 3000) : $urandom_range(0, knee);
        return 16'($urandom_range(lo, knee));
    endfunction

    // Send a pulse train carrying data and check bits; the last pulse is
    // marked. A register transfer goes in before pulse reg_at if nonzero.
    task automatic send_frame(input logic [31:0] data, input logic [3:0] chk,
                              input int npulses, input int reg_at);
        in_item_t item;
        int       k;
        for (k = 1; k <= npulses; k++)
        begin
            if (k == reg_at)
                offer_register(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            item.opcode      = OP_PULSE;
            item.last_pulse  = (k == npulses);
            item.sensor_id   = 8'($urandom_range(0, 255));
            item.target_slot = 8'($urandom_range(0, 255));
            if (k % 2 == 0 && k >= DATA_FIRST && k <= DATA_LAST)
                item.pulse_length = pulse_for(data[(k - 2) / 2]);
            else if (k % 2 == 0 && k >= CHECK_FIRST && k <= CHECK_LAST)
                item.pulse_length = pulse_for(chk[(k - 66) / 2]);
            else
            begin
                case ($urandom_range(0, 3))
                    0:       item.pulse_length = 16'h0000;
                    1:       item.pulse_length = 16'hFFFF;
                    default: item.pulse_length = 16'($urandom_range(0, 65535));
                endcase
            end
            offer_item(item);
        end
    endtask

    task automatic send_message(input logic [31:0] data);
        send_frame(data, nibble_check(data), FRAME_PULSES, 0);
    endtask

    // Wait until every expected report is in, then let the pipeline settle.
    // Step past the next edge first so the last input transfer is already predicted.
    task automatic wait_drained();
        input_idle();
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [15:0] thr, input logic [7:0] scl);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_THRESHOLD;
        cfg_data  <= thr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_SCALE;
        cfg_data  <= {8'd0, scl};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random message of a random type, mostly from a known sensor
    function automatic logic [31:0] pick_message();
        logic [31:0] d;
        logic [3:0]  n2;
        logic [3:0]  n3;
        d  = $urandom;
        n2 = 4'($urandom_range(0, 15)) | N2_MASK;
        n3 = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 4))
            0:
            begin
                n2 = 4'($urandom_range(0, 15));
                if ((n2 & N2_MASK) == N2_MASK)
                    n2 = n2 ^ 4'h2;
            end
            1:
            begin
                n3 = N3_RAIN;
                if ($urandom_range(0, 9) == 0)
                    rain_counter = 16'($urandom_range(0, 65535));
                else
                    rain_counter = rain_counter + 16'($urandom_range(0, 60));
                d[31:16] = rain_counter;
            end
            2:       n3 = N3_WIND;
            3:       n3 = 4'($urandom_range(0, 15)) | N3_DIR_MASK;
            default:
            begin
                if (n3 == N3_RAIN || n3 == N3_WIND || (n3 & N3_DIR_MASK) == N3_DIR_MASK)
                    n3 = 4'h0;
            end
        endcase
        d[11:8]  = n2;
        d[15:12] = n3;
        if ($urandom_range(0, 3) != 0)
            d[7:0] = known_ids[$urandom_range(0, 4)];
        return d;
    endfunction

    // One random event: mostly clean frames, some broken ones, some
    // registrations and short noise bursts that end a frame
    task automatic random_event();
        logic [31:0] d;
        logic [3:0]  chk;
        int          npulses;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            d   = pick_message();
            chk = nibble_check(d);
            if ($urandom_range(0, 9) == 0)
                chk = chk ^ 4'($urandom_range(1, 15));
            send_frame(d, chk, FRAME_PULSES,
                       ($urandom_range(0, 19) == 0) ? $urandom_range(1, 74) : 0);
        end
        else if (pick < 80)
        begin
            npulses = $urandom_range(1, 90);
            if (npulses == FRAME_PULSES)
                npulses = FRAME_PULSES - 1;
            d = pick_message();
            send_frame(d, nibble_check(d), npulses, 0);
        end
        else if (pick < 90)
            offer_register(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        else
            send_frame($urandom, 4'($urandom_range(0, 15)), $urandom_range(1, 6), 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Fill the roster, hit every refusal, and the free-entry match of code 0
    task automatic test_sensor_table();
        offer_register(ID_A, 8'd10);
        offer_register(ID_B, 8'd20);
        offer_register(ID_C, 8'd255);
        offer_register(ID_D, 8'd1);
        offer_register(8'h44, 8'd0);        // zero slot: refused
        offer_register(ID_A, 8'd99);        // id already mapped: refused
        offer_register(8'h00, 8'd7);        // lands in the free entry, stays free
        send_message(32'h0000_0100);        // code 0 finds that entry's slot
        offer_register(ID_E, 8'd3);         // takes the same entry
        offer_register(8'h77, 8'd5);        // roster full: refused
        send_message(32'h0000_0100);        // code 0 now unregistered
    endtask

    // Message types with field extremes and the rain base sequence
    task automatic test_message_kinds();
        send_message({16'h9980, 8'h01, ID_A});   // coldest temperature
        send_message({16'h0010, 8'h36, ID_B});   // rain while base is zero
        send_message({16'h0025, 8'h36, ID_B});   // rain delta
        send_message({16'h0005, 8'h36, ID_B});   // counter fell: base follows
        send_message({16'hC800, 8'h1E, ID_C});   // wind speed
        send_message({16'h40FF, 8'hF7, ID_D});   // direction field all ones
    endtask

    // Checksum failure with a registration in the middle of the frame, a
    // lone pulse, and count saturation
    task automatic test_frame_faults();
        logic [31:0] d;
        d = {16'h5512, 8'h31, ID_A};
        send_frame(d, nibble_check(d) ^ 4'h5, FRAME_PULSES, 30);
        send_frame(d, nibble_check(d), 1, 0);
        send_frame(d, nibble_check(d), 256, 0);
    endtask

    // Scale zero turns every pulse into a zero bit
    task automatic test_threshold_settings();
        logic [31:0] d;
        d = {16'hA5C3, 8'h11, ID_A};
        set_config(16'h0100, 8'd0);
        send_message(d);
        set_config(THRESHOLD_RESET, SCALE_RESET);
    endtask

    // Hold the output off for a long stretch while items keep coming, so the
    // block fills up and stalls its input
    task automatic test_output_hold_off();
        in_item_t item;
        int       i;
        wait_drained();
        hold_request = 90;
        for (i = 0; i < 40; i++)
        begin
            if (i % 2 == 0)
                offer_register(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
            begin
                item.opcode       = OP_PULSE;
                item.pulse_length = 16'($urandom_range(0, 65535));
                item.last_pulse   = 1'b1;
                item.sensor_id    = 8'($urandom_range(0, 255));
                item.target_slot  = 8'($urandom_range(0, 255));
                offer_item(item);
            end
        end
        wait_drained();
    endtask

    // Random traffic in phases, each with its own configuration
    task automatic test_random_traffic();
        int phase;
        int items_start;
        int reports_start;
        for (phase = 0; phase < 2; phase++)
        begin
            if (phase == 0)
                set_config(THRESHOLD_RESET, SCALE_RESET);
            else
                set_config(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 255)));
            items_start   = items_sent;
            reports_start = reports_predicted;
            while (items_sent - items_start < 40 || reports_predicted - reports_start < 1)
                random_event();
        end
    endtask

    // Last stretch with no idling on either side
    task automatic test_steady_stream();
        int i;
        calm_tail = 1'b1;
        for (i = 0; i < 2; i++)
            random_event();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            roster_id[i]   = '0;
            roster_slot[i] = '0;
        end
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sensor_table();
        test_message_kinds();
        test_frame_faults();
        test_threshold_settings();
        test_output_hold_off();
        test_random_traffic();
        test_steady_stream();
        wait_drained();

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
